// ===== rtl/amfm_pkg.sv =====
// ----------------------------------------------------------------------------
// amfm_pkg
// Shared types, constants and the sine table generator for the AM/FM tone
// generator.
// ----------------------------------------------------------------------------
package amfm_pkg;

    // Parameter defaults
    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF    = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE         = 3'd0,
        REG_CARRIER_STEP = 3'd1,
        REG_AM_STEP      = 3'd2,
        REG_FM_STEP      = 3'd3,
        REG_PEAK_LEVEL   = 3'd4,
        REG_AM_INDEX     = 3'd5,
        REG_FM_DEVIATION = 3'd6,
        REG_NORM_GAIN    = 3'd7
    } reg_idx_t;

    // Modulation modes (code 3 behaves as combined)
    localparam logic [1:0] MODE_AM   = 2'd0;
    localparam logic [1:0] MODE_FM   = 2'd1;
    localparam logic [1:0] MODE_BOTH = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] carrier_step;
        logic [31:0] am_step;
        logic [31:0] fm_step;
        logic [14:0] peak_level;
        logic [15:0] am_index;
        logic [30:0] fm_deviation;
        logic [15:0] norm_gain;
    } amfm_cfg_t;

    localparam logic [15:0] NORM_GAIN_RST = 16'd32768;

    // Fixed-point widths
    localparam int SINE_W  = 16;
    localparam int FRAC_SH = 15;
    localparam int ONE_Q15 = 32768;
    localparam int MUL_A_W = 31;   // widest A operand: fm_deviation
    localparam int MUL_B_W = 18;   // widest B operand: level magnitude
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int RND_W   = PROD_W + 2;
    localparam int ENV_W   = 18;
    localparam int LVL1_W  = 18;
    localparam int LVL_W   = 19;

    typedef logic signed [SINE_W-1:0] sine_t;

    // Datapath control
    typedef enum logic [1:0] {
        ROM_AM,
        ROM_FM,
        ROM_CAR
    } rom_sel_t;

    typedef enum logic [2:0] {
        OP_AM,
        OP_FM,
        OP_PEAK,
        OP_GAIN,
        OP_OUT
    } mul_op_t;

    typedef struct packed {
        rom_sel_t rom_sel;
        mul_op_t  mul_op;
        logic     ld_last;
        logic     ld_env;
        logic     ld_cphase;
        logic     ld_lvl1;
        logic     ld_csin;
        logic     ld_lvl;
        logic     ld_out;    // also steps or clears the phases
    } amfm_cmd_t;

    // Sine table generation, evaluated at elaboration
    localparam longint ONE_Q30 = 64'sd1073741824;
    localparam longint POLY_C [5] = '{
        64'sd1686629713, -64'sd693598668, 64'sd85569306, -64'sd5026995, 64'sd172272
    };

    function automatic longint quarter_sine(input longint x);
        longint x2;
        longint p;
        longint y;
        x2 = (x * x) / ONE_Q30;
        p  = POLY_C[4];
        for (int k = 3; k >= 0; k--)
        begin
            p = POLY_C[k] + (p * x2) / ONE_Q30;
        end
        y = (p * x) / ONE_Q30;
        if (y < 0)
        begin
            y = 0;
        end
        if (y > ONE_Q30)
        begin
            y = ONE_Q30;
        end
        return (y * 32767 + (64'sd1 << 29)) >>> 30;
    endfunction

    function automatic sine_t sine_entry(input int a, input int addr_bits);
        longint qsize;
        longint q;
        longint r;
        longint n;
        longint v;
        qsize = 64'sd1 << (addr_bits - 2);
        q     = longint'(a) >>> (addr_bits - 2);
        r     = longint'(a) & (qsize - 1);
        n     = (q % 2 == 1) ? (qsize - r) : r;
        v     = quarter_sine(n << (30 - (addr_bits - 2)));
        return SINE_W'((q >= 2) ? -v : v);
    endfunction

endpackage

// ===== rtl/am_fm_tone_generator_unit.sv =====
// One beat at a time: in_ready is high only when idle, so a new beat is taken
// once the last sample is in the output register. The single shared multiplier
// and the single read port of the sine ROM are used in turn by each pass.
// A finished sample waits in the output register while the next beat starts.
// Reset (rst_n, async, active low) clears phases, config and control; norm_gain = 1.0.
// ----------------------------------------------------------------------------
// am_fm_tone_generator_unit
// DDS tone generator with AM, FM or combined modulation, Q1.15 arithmetic.
// ----------------------------------------------------------------------------
module am_fm_tone_generator_unit #(
    parameter int PHASE_BITS     = amfm_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = amfm_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS    = amfm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                last_of_buffer,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_BITS-1:0]       sample,
    output logic                                last,
    input  logic                                cfg_we,
    input  logic [amfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [amfm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import amfm_pkg::*;

    amfm_cfg_t cfg;
    amfm_cmd_t cmd;

    amfm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    amfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    amfm_datapath #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cmd     (cmd),
        .last_in (last_of_buffer),
        .sample  (sample),
        .last    (last)
    );

endmodule

// ===== rtl/amfm_sine_rom.sv =====
// ----------------------------------------------------------------------------
// amfm_sine_rom
// Full-wave sine lookup, Q1.15, one registered read port.
// ----------------------------------------------------------------------------
module amfm_sine_rom #(
    parameter int SINE_ADDR_BITS = amfm_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                      clk,
    input  logic [SINE_ADDR_BITS-1:0] addr,
    output amfm_pkg::sine_t           rd_data
);
    import amfm_pkg::*;

    localparam int DEPTH = 1 << SINE_ADDR_BITS;

    typedef sine_t rom_t [DEPTH];

    function automatic rom_t build_rom();
        rom_t t;
        for (int i = 0; i < DEPTH; i++)
        begin
            t[i] = sine_entry(i, SINE_ADDR_BITS);
        end
        return t;
    endfunction

    localparam rom_t SINE_TBL = build_rom();

    sine_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= SINE_TBL[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/amfm_cfg.sv =====
// ----------------------------------------------------------------------------
// amfm_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module amfm_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [amfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [amfm_pkg::CFG_DATA_W-1:0]     cfg_data,
    output amfm_pkg::amfm_cfg_t                 cfg
);
    import amfm_pkg::*;

    amfm_cfg_t cfg_reg;
    amfm_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MODE:         cfg_next.mode         = cfg_data[1:0];
                REG_CARRIER_STEP: cfg_next.carrier_step = cfg_data[31:0];
                REG_AM_STEP:      cfg_next.am_step      = cfg_data[31:0];
                REG_FM_STEP:      cfg_next.fm_step      = cfg_data[31:0];
                REG_PEAK_LEVEL:   cfg_next.peak_level   = cfg_data[14:0];
                REG_AM_INDEX:     cfg_next.am_index     = cfg_data[15:0];
                REG_FM_DEVIATION: cfg_next.fm_deviation = cfg_data[30:0];
                REG_NORM_GAIN:    cfg_next.norm_gain    = cfg_data[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg           <= '0;
            cfg_reg.norm_gain <= NORM_GAIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/amfm_datapath.sv =====
// ----------------------------------------------------------------------------
// amfm_datapath
// Phase accumulators, sine ROM, shared rounding multiplier and output register.
// ----------------------------------------------------------------------------
module amfm_datapath #(
    parameter int PHASE_BITS     = amfm_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = amfm_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS    = amfm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  amfm_pkg::amfm_cfg_t           cfg,
    input  amfm_pkg::amfm_cmd_t           cmd,
    input  logic                          last_in,
    output logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          last
);
    import amfm_pkg::*;

    localparam int SH_OUT = 31 - SAMPLE_BITS;
    localparam logic [PROD_W:0] HALF_FRAC = (PROD_W+1)'(1) << (FRAC_SH - 1);
    localparam logic [PROD_W:0] HALF_OUT  = (PROD_W+1)'(1) << (SH_OUT - 1);
    localparam logic signed [RND_W-1:0] SAT_HI = (RND_W'(1) << (SAMPLE_BITS - 1)) - RND_W'(1);
    localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);
    localparam logic signed [ENV_W-1:0] ENV_ONE = ENV_W'(ONE_Q15);

    logic [PHASE_BITS-1:0] carrier_phase_reg;
    logic [PHASE_BITS-1:0] am_phase_reg;
    logic [PHASE_BITS-1:0] fm_phase_reg;
    logic [PHASE_BITS-1:0] cphase_reg;

    logic                     last_flag_reg;
    logic signed [ENV_W-1:0]  env_reg;
    logic signed [LVL1_W-1:0] lvl1_reg;
    logic signed [LVL_W-1:0]  lvl_reg;
    sine_t                    csin_reg;

    logic [PROD_W-1:0] prod_reg;
    logic              neg_reg;
    logic              out_sh_reg;

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          last_reg;

    logic use_am;
    logic use_fm;

    logic [SINE_ADDR_BITS-1:0] rom_addr;
    sine_t                     rom_data;

    logic [SINE_W-1:0] rom_abs;
    logic [SINE_W-1:0] csin_abs;
    logic [ENV_W-1:0]  env_abs;
    logic [LVL1_W-1:0] lvl1_abs;
    logic [LVL_W-1:0]  lvl_abs;

    logic [MUL_A_W-1:0] op_a;
    logic [MUL_B_W-1:0] op_b;
    logic               op_neg;
    logic [PROD_W-1:0]  prod_next;

    logic [PROD_W:0]         rnd_sum;
    logic [PROD_W:0]         rnd_mag;
    logic signed [RND_W-1:0] rnd_s;
    logic signed [SAMPLE_BITS-1:0] sat;

    // mode 3 runs as combined
    assign use_am = (cfg.mode != MODE_FM);
    assign use_fm = (cfg.mode != MODE_AM);

    always_comb
    begin
        case (cmd.rom_sel)
            ROM_AM:  rom_addr = am_phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
            ROM_FM:  rom_addr = fm_phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
            ROM_CAR: rom_addr = cphase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
            default: rom_addr = am_phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS];
        endcase
    end

    amfm_sine_rom #(
        .SINE_ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom (
        .clk     (clk),
        .addr    (rom_addr),
        .rd_data (rom_data)
    );

    // Sign-magnitude operands for the shared multiplier
    assign rom_abs  = rom_data[SINE_W-1] ? SINE_W'(-rom_data) : rom_data;
    assign csin_abs = csin_reg[SINE_W-1] ? SINE_W'(-csin_reg) : csin_reg;
    assign env_abs  = env_reg[ENV_W-1]   ? ENV_W'(-env_reg)   : env_reg;
    assign lvl1_abs = lvl1_reg[LVL1_W-1] ? LVL1_W'(-lvl1_reg) : lvl1_reg;
    assign lvl_abs  = lvl_reg[LVL_W-1]   ? LVL_W'(-lvl_reg)   : lvl_reg;

    always_comb
    begin
        case (cmd.mul_op)
            OP_AM:
            begin
                op_a   = MUL_A_W'(cfg.am_index);
                op_b   = MUL_B_W'(rom_abs);
                op_neg = rom_data[SINE_W-1];
            end
            OP_FM:
            begin
                op_a   = MUL_A_W'(cfg.fm_deviation);
                op_b   = MUL_B_W'(rom_abs);
                op_neg = rom_data[SINE_W-1];
            end
            OP_PEAK:
            begin
                op_a   = MUL_A_W'(cfg.peak_level);
                op_b   = MUL_B_W'(env_abs);
                op_neg = env_reg[ENV_W-1];
            end
            OP_GAIN:
            begin
                op_a   = use_am ? MUL_A_W'(cfg.norm_gain) : MUL_A_W'(ONE_Q15);
                op_b   = MUL_B_W'(lvl1_abs);
                op_neg = lvl1_reg[LVL1_W-1];
            end
            OP_OUT:
            begin
                op_a   = MUL_A_W'(csin_abs);
                op_b   = MUL_B_W'(lvl_abs);
                op_neg = csin_reg[SINE_W-1] ^ lvl_reg[LVL_W-1];
            end
            default:
            begin
                op_a   = '0;
                op_b   = '0;
                op_neg = 1'b0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    // Round half away from zero on the registered product
    assign rnd_sum = {1'b0, prod_reg} + (out_sh_reg ? HALF_OUT : HALF_FRAC);
    assign rnd_mag = out_sh_reg ? (rnd_sum >> SH_OUT) : (rnd_sum >> FRAC_SH);
    assign rnd_s   = neg_reg ? -$signed({1'b0, rnd_mag}) : $signed({1'b0, rnd_mag});

    always_comb
    begin
        if (rnd_s > SAT_HI)
        begin
            sat = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (rnd_s < SAT_LO)
        begin
            sat = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            sat = rnd_s[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        neg_reg    <= op_neg;
        out_sh_reg <= (cmd.mul_op == OP_OUT);
        if (cmd.ld_last)
        begin
            last_flag_reg <= last_in;
        end
        if (cmd.ld_env)
        begin
            env_reg <= use_am ? ENV_ONE + rnd_s[ENV_W-1:0] : ENV_ONE;
        end
        if (cmd.ld_cphase)
        begin
            cphase_reg <= carrier_phase_reg + (use_fm ? rnd_s[PHASE_BITS-1:0] : '0);
        end
        if (cmd.ld_lvl1)
        begin
            lvl1_reg <= rnd_s[LVL1_W-1:0];
        end
        if (cmd.ld_csin)
        begin
            csin_reg <= rom_data;
        end
        if (cmd.ld_lvl)
        begin
            lvl_reg <= rnd_s[LVL_W-1:0];
        end
        if (cmd.ld_out)
        begin
            sample_reg <= sat;
            last_reg   <= last_flag_reg;
        end
    end

    // Phases step after each sample; clear after end of buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_phase_reg <= '0;
            am_phase_reg      <= '0;
            fm_phase_reg      <= '0;
        end
        else if (cmd.ld_out)
        begin
            if (last_flag_reg)
            begin
                carrier_phase_reg <= '0;
                am_phase_reg      <= '0;
                fm_phase_reg      <= '0;
            end
            else
            begin
                carrier_phase_reg <= carrier_phase_reg + PHASE_BITS'(cfg.carrier_step);
                am_phase_reg      <= am_phase_reg + PHASE_BITS'(cfg.am_step);
                fm_phase_reg      <= fm_phase_reg + PHASE_BITS'(cfg.fm_step);
            end
        end
    end

    assign sample = sample_reg;
    assign last   = last_reg;

endmodule

// ===== rtl/amfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// amfm_ctrl
// Sequencer for one sample: ROM reads, multiplier passes, output hand-off.
// ----------------------------------------------------------------------------
module amfm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output amfm_pkg::amfm_cmd_t cmd
);
    import amfm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AM_RD,
        ST_FM_RD,
        ST_FM_MUL,
        ST_PHASE,
        ST_CAR_RD,
        ST_GAIN,
        ST_LVL,
        ST_OUT_MUL,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd         = '0;
        cmd.rom_sel = ROM_AM;
        cmd.mul_op  = OP_AM;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ld_last = 1'b1;
                if (in_valid)
                begin
                    state_next = ST_AM_RD;
                end
            end
            ST_AM_RD:
            begin
                cmd.rom_sel = ROM_AM;
                state_next  = ST_FM_RD;
            end
            ST_FM_RD:
            begin
                // AM sine is on the ROM output now
                cmd.rom_sel = ROM_FM;
                cmd.mul_op  = OP_AM;
                state_next  = ST_FM_MUL;
            end
            ST_FM_MUL:
            begin
                cmd.mul_op = OP_FM;
                cmd.ld_env = 1'b1;
                state_next = ST_PHASE;
            end
            ST_PHASE:
            begin
                cmd.ld_cphase = 1'b1;
                cmd.mul_op    = OP_PEAK;
                state_next    = ST_CAR_RD;
            end
            ST_CAR_RD:
            begin
                cmd.rom_sel = ROM_CAR;
                cmd.ld_lvl1 = 1'b1;
                state_next  = ST_GAIN;
            end
            ST_GAIN:
            begin
                cmd.ld_csin = 1'b1;
                cmd.mul_op  = OP_GAIN;
                state_next  = ST_LVL;
            end
            ST_LVL:
            begin
                cmd.ld_lvl = 1'b1;
                state_next = ST_OUT_MUL;
            end
            ST_OUT_MUL:
            begin
                cmd.mul_op = OP_OUT;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // keep the output product in the multiplier register while waiting
                cmd.mul_op = OP_OUT;
                // hold until the output register can take the beat
                if (out_free)
                begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.ld_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== tb/am_fm_tone_generator_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// am_fm_tone_generator_unit_tb
// Drives tick beats into the AM/FM tone generator under a range of register
// settings and compares every output beat with a bit-true software model of
// the phase accumulators, sine table and Q1.15 gain chain.
// ----------------------------------------------------------------------------
module am_fm_tone_generator_unit_tb;
    import amfm_pkg::*;

    localparam logic [1:0] MODE_SPARE    = 2'd3;   // unused code, acts as combined
    localparam int         SETTLE_CYCLES = 12;
    localparam int         RANDOM_SETS   = 12;
    localparam int         TICKS_PER_SET = 160;
    localparam longint     Q30           = 64'sd1 << 30;

    typedef struct {
        logic signed [15:0] sample;
        logic               last;
    } tone_beat_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  in_valid       = 1'b0;
    logic                  in_ready;
    logic                  last_of_buffer = 1'b0;
    logic                  out_valid;
    logic                  out_ready      = 1'b0;
    logic signed [15:0]    sample;
    logic                  last;
    logic                  cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    // model state
    logic signed [15:0] sine_lut [0:1023];
    amfm_cfg_t          cfg_model;
    logic [31:0]        carrier_ph;
    logic [31:0]        am_ph;
    logic [31:0]        fm_ph;
    tone_beat_t         pending_tones [$];
    tone_beat_t         want;

    bit tx_gaps   = 1'b1;
    bit rx_stalls = 1'b1;
    int rx_hold   = 0;
    int err_count = 0;
    int n_checked = 0;
    int n_ends    = 0;
    int n_settings = 0;

    am_fm_tone_generator_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .last_of_buffer (last_of_buffer),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample         (sample),
        .last           (last),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        #15_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // odd polynomial over one quarter turn, Q30 in, Q15 magnitude out
    function automatic longint quarter_wave(input longint x);
        longint x2;
        longint acc;
        longint y;
        x2  = (x * x) / Q30;
        acc = 64'sd172272;
        acc = -64'sd5026995 + (acc * x2) / Q30;
        acc = 64'sd85569306 + (acc * x2) / Q30;
        acc = -64'sd693598668 + (acc * x2) / Q30;
        acc = 64'sd1686629713 + (acc * x2) / Q30;
        y   = (acc * x) / Q30;
        if (y < 0)
        begin
            y = 0;
        end
        if (y > Q30)
        begin
            y = Q30;
        end
        return (y * 32767 + (64'sd1 << 29)) >>> 30;
    endfunction

    initial
    begin
        int     q;
        int     r;
        longint v;
        for (int a = 0; a < 1024; a++)
        begin
            q = a >> 8;
            r = a & 255;
            v = quarter_wave(longint'((q % 2 == 1) ? 256 - r : r) << 22);
            sine_lut[a] = (q >= 2) ? 16'(-v) : 16'(v);
        end
    end

    // product rounded half away from zero
    function automatic longint rmul(input longint a, input longint b, input int sh);
        longint ma;
        longint mb;
        longint r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        r  = (ma * mb + (64'sd1 << (sh - 1))) >>> sh;
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint sine_at(input logic [31:0] ph);
        return longint'(sine_lut[ph[31:22]]);
    endfunction

    function automatic tone_beat_t next_tone_sample(input logic lob);
        tone_beat_t  b;
        longint      env;
        longint      gain;
        longint      lvl;
        longint      s;
        longint      off;
        logic [31:0] cph;
        env  = 32768;
        gain = 32768;
        cph  = carrier_ph;
        if (cfg_model.mode != MODE_FM)
        begin
            env  = 32768 + rmul(longint'(cfg_model.am_index), sine_at(am_ph), FRAC_SH);
            gain = longint'(cfg_model.norm_gain);
        end
        if (cfg_model.mode != MODE_AM)
        begin
            off = rmul(longint'(cfg_model.fm_deviation), sine_at(fm_ph), FRAC_SH);
            cph = carrier_ph + off[31:0];
        end
        lvl = rmul(rmul(longint'(cfg_model.peak_level), env, FRAC_SH), gain, FRAC_SH);
        s   = rmul(lvl, sine_at(cph), FRAC_SH);
        if (s > 32767)
        begin
            s = 32767;
        end
        if (s < -32768)
        begin
            s = -32768;
        end
        b.sample = s[15:0];
        b.last   = lob;
        // phases step after the sample is formed, clear after a buffer end
        if (lob)
        begin
            carrier_ph = '0;
            am_ph      = '0;
            fm_ph      = '0;
        end
        else
        begin
            carrier_ph = carrier_ph + cfg_model.carrier_step;
            am_ph      = am_ph + cfg_model.am_step;
            fm_ph      = fm_ph + cfg_model.fm_step;
        end
        return b;
    endfunction

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= 10)
        begin
            $display("ERROR: %s", msg);
        end
    endfunction

    // output side: compare each beat, then hold ready low for a random stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_hold = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_tones.size() == 0)
                begin
                    note_error($sformatf("unexpected beat: sample %0d last %0b",
                                         sample, last));
                end
                else
                begin
                    want = pending_tones.pop_front();
                    n_checked++;
                    if (sample !== want.sample || last !== want.last)
                    begin
                        note_error($sformatf(
                            "beat %0d: expected sample %0d last %0b, got sample %0d last %0b",
                            n_checked, want.sample, want.last, sample, last));
                    end
                end
                rx_hold = rx_stalls ? $urandom_range(0, 9) : 0;
            end
            if (rx_hold > 0)
            begin
                out_ready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_tone(input logic lob);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        last_of_buffer <= lob;
        do
            @(posedge clk);
        while (!in_ready);
        pending_tones.push_back(next_tone_sample(lob));
        if (lob)
        begin
            n_ends++;
        end
    endtask

    task automatic send_run(input int n, input int last_at);
        for (int i = 0; i < n; i++)
        begin
            send_tone(i == last_at);
        end
    endtask

    task automatic drain_tones();
        in_valid <= 1'b0;
        while (pending_tones.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes all eight registers; junk sets bits above each register's width
    task automatic load_settings(input amfm_cfg_t c, input bit junk);
        reg_idx_t    idx;
        logic [31:0] val;
        int          w;
        for (int i = 0; i < 8; i++)
        begin
            idx = reg_idx_t'(i);
            case (idx)
                REG_MODE:         begin val = 32'(c.mode);         w = 2;  end
                REG_CARRIER_STEP: begin val = c.carrier_step;      w = 32; end
                REG_AM_STEP:      begin val = c.am_step;           w = 32; end
                REG_FM_STEP:      begin val = c.fm_step;           w = 32; end
                REG_PEAK_LEVEL:   begin val = 32'(c.peak_level);   w = 15; end
                REG_AM_INDEX:     begin val = 32'(c.am_index);     w = 16; end
                REG_FM_DEVIATION: begin val = 32'(c.fm_deviation); w = 31; end
                default:          begin val = 32'(c.norm_gain);    w = 16; end
            endcase
            if (junk && w < 32)
            begin
                val = val | (32'($urandom) << w);
            end
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cfg_model = c;
        n_settings++;
    endtask

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 32'h00FF_FFFF);
            1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_q15();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // reset settings: zero level, so every sample is zero
    task automatic test_reset_state();
        send_run(3, 1);
        drain_tones();
    endtask

    task automatic test_directed_modes();
        // quarter-turn steps land on the sine peaks and zero crossings
        load_settings('{mode: MODE_AM, carrier_step: 32'h4000_0000,
                        am_step: 32'h4000_0000, fm_step: 32'h0,
                        peak_level: 15'h7FFF, am_index: 16'd32768,
                        fm_deviation: 31'h0, norm_gain: 16'd32768}, 1'b0);
        send_run(5, 4);
        drain_tones();
        // oversized gains in the spare mode: output saturates
        load_settings('{mode: MODE_SPARE, carrier_step: 32'h4000_0000,
                        am_step: 32'hC000_0000, fm_step: 32'hFFFF_FFFF,
                        peak_level: 15'h7FFF, am_index: 16'hFFFF,
                        fm_deviation: 31'h7FFF_FFFF, norm_gain: 16'hFFFF}, 1'b1);
        send_run(5, -1);
        drain_tones();
        // FM only: norm_gain of zero must have no effect
        load_settings('{mode: MODE_FM, carrier_step: 32'h0123_4567,
                        am_step: 32'hFFFF_FFFF, fm_step: 32'h8000_0000,
                        peak_level: 15'd16384, am_index: 16'd32768,
                        fm_deviation: 31'h7FFF_FFFF, norm_gain: 16'd0}, 1'b0);
        send_run(5, 2);
        drain_tones();
        // combined with zero gain gives silence
        load_settings('{mode: MODE_BOTH, carrier_step: 32'hFFFF_FFFF,
                        am_step: 32'hFFFF_FFFF, fm_step: 32'hFFFF_FFFF,
                        peak_level: 15'h7FFF, am_index: 16'd0,
                        fm_deviation: 31'h1234_5678, norm_gain: 16'd0}, 1'b0);
        send_run(4, 3);
        drain_tones();
        // tiny level exercises rounding
        load_settings('{mode: MODE_AM, carrier_step: 32'h0800_0000,
                        am_step: 32'h1000_0000, fm_step: 32'h0,
                        peak_level: 15'd1, am_index: 16'd32768,
                        fm_deviation: 31'h0, norm_gain: 16'd23170}, 1'b0);
        send_run(3, -1);
        drain_tones();
    endtask

    task automatic test_random_settings();
        amfm_cfg_t c;
        for (int k = 0; k < RANDOM_SETS; k++)
        begin
            tx_gaps   = (k % 4 == 0) || (k % 4 == 1);
            rx_stalls = (k % 4 == 0) || (k % 4 == 2);
            c.mode         = (k < 4) ? 2'(k) : 2'($urandom_range(0, 3));
            c.carrier_step = pick_step();
            c.am_step      = pick_step();
            c.fm_step      = pick_step();
            c.peak_level   = ($urandom_range(0, 3) == 0) ?
                             ($urandom_range(0, 1) ? 15'h7FFF : 15'h0) :
                             15'($urandom_range(0, 32767));
            c.am_index     = pick_q15();
            c.norm_gain    = pick_q15();
            c.fm_deviation = $urandom_range(0, 1) ? 31'($urandom) :
                             31'($urandom_range(0, 32'h0010_0000));
            load_settings(c, 1'($urandom_range(0, 1)));
            for (int i = 0; i < TICKS_PER_SET; i++)
            begin
                send_tone($urandom_range(0, 23) == 0);
            end
            drain_tones();
        end
    endtask

    initial
    begin
        cfg_model           = '0;
        cfg_model.norm_gain = NORM_GAIN_RST;
        carrier_ph          = '0;
        am_ph               = '0;
        fm_ph               = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_modes();
        test_random_settings();
        $display("%0d samples checked over %0d register settings (AM, FM, combined, spare)",
                 n_checked, n_settings);
        $display("%0d buffer ends, random gaps and stalls on both sides, %0d errors",
                 n_ends, err_count);
        if (err_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
